[src/kpt_pkg.sv]
// Shared constants and field layout for the keyframe progress timer.
package kpt_pkg;

   localparam int TIME_BITS     = 32;
   localparam int FRACTION_BITS = 16;
   localparam int POS_BITS      = FRACTION_BITS + 1;
   localparam int PHASE_BITS    = 2;

   // serial datapath: digit width and digit count per time word
   localparam int DIGIT_BITS    = 4;
   localparam int DIGITS        = TIME_BITS / DIGIT_BITS;
   localparam int DIGIT_CNT_BITS = $clog2(DIGITS);
   localparam int DIV_CNT_BITS  = $clog2(FRACTION_BITS);

   // stream payload layout
   localparam int REQ_FIELD_BITS = 1 + TIME_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = POS_BITS + PHASE_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PHASE_LSB  = POS_BITS;
   localparam int RSP_EVENT_BIT  = POS_BITS + PHASE_BITS;

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DURATION = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOPING  = 2'd2;

   // operation codes carried in tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_PLAY = 1'b1;

   // phase codes
   localparam logic [PHASE_BITS-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_BITS-1:0] PH_DELAY = 2'd1;
   localparam logic [PHASE_BITS-1:0] PH_TRANS = 2'd2;

   // 1.0 in unsigned Q1.FRACTION_BITS
   localparam logic [POS_BITS-1:0] FIX_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [POS_BITS-1:0]  pos_type;

endpackage

[src/kpt_divider.sv]
// Restoring divider: floor(num * 2^FRACTION_BITS / den), one quotient bit per cycle.
module kpt_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  kpt_pkg::time_type                    num,   // must be below den
   input  kpt_pkg::time_type                    den,
   output logic                                 done,
   output logic [kpt_pkg::FRACTION_BITS-1:0]    quot
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [kpt_pkg::DIV_CNT_BITS-1:0]       cnt_ff, cnt_in;
   kpt_pkg::time_type                      rem_ff, rem_in;
   logic [kpt_pkg::FRACTION_BITS-1:0]      quot_ff, quot_in;

   logic [kpt_pkg::TIME_BITS:0]            shifted;
   logic [kpt_pkg::TIME_BITS+1:0]          trial;
   logic                                   fits;

   // remainder stays below den, so the shifted value fits one extra bit
   assign shifted = {rem_ff, 1'b0};
   assign trial   = {1'b0, shifted} - {2'b00, den};
   assign fits    = ~trial[kpt_pkg::TIME_BITS+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[kpt_pkg::TIME_BITS-1:0] : shifted[kpt_pkg::TIME_BITS-1:0];
         quot_in = {quot_ff[kpt_pkg::FRACTION_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == kpt_pkg::DIV_CNT_BITS'(kpt_pkg::FRACTION_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[src/keyframe_progress_timer.sv]
// Top level of the keyframe progress timer: phase control, serial time datapath, result register.
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tuser: operation; tdata: direction, now_ms
//  rsp_     out  rsp_tvalid/rsp_tready  tdata: position, phase, progress_event
//  csr_     in   csr_wen (no stall)     csr_index, csr_wdata
//
//  Play and idle ticks go straight to the result state; a delay tick makes one digit pass;
//  a transition tick makes more: time differences and compares run 4 bits per cycle
//  through shift registers (a digit pass, a second pass on looping overrun), and
//  the position comes from a restoring divider at one quotient bit per cycle
//  (16 bit steps, started from state S_DIVGO).
//  One item is worked at a time; req_tready is high only while nothing is in flight.
//  A finished result waits in the output register while the next item is accepted.
//  Reset is synchronous, active high, and returns to idle phase with control, timer and configuration state zero.
module keyframe_progress_timer (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [kpt_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // [0] direction, [32:1] now_ms
   input  logic                                  req_tuser,  // [0] operation
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [kpt_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // [16:0] position, [18:17] phase,
                                                             // [19] progress_event
   // configuration writes
   input  logic                                  csr_wen,
   input  logic [kpt_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [kpt_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int D = kpt_pkg::DIGIT_BITS;
   localparam int T = kpt_pkg::TIME_BITS;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PASS1 = 3'd1;  // elapsed = now - start, compare to limit
   localparam logic [2:0] S_PASS2 = 3'd2;  // loop wrap: elapsed -= duration, start += duration
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                          state_ff, state_in;

   // configuration
   kpt_pkg::time_type                   duration_ff, delay_ff;
   logic                                looping_ff;

   // timer state
   logic [kpt_pkg::PHASE_BITS-1:0]      phase_ff, phase_in;
   logic                                reverse_ff, reverse_in;
   kpt_pkg::time_type                   delay_start_ff, delay_start_in;
   kpt_pkg::time_type                   tstart_ff, tstart_in;
   kpt_pkg::pos_type                    position_ff, position_in;
   logic                                event_ff, event_in;

   // serial datapath
   kpt_pkg::time_type                   now_ff, now_in;
   kpt_pkg::time_type                   elap_ff, elap_in;
   kpt_pkg::time_type                   opnd_ff, opnd_in;
   kpt_pkg::time_type                   cmp_ff, cmp_in;
   logic                                borrow_ff, borrow_in;
   logic                                carry_ff, carry_in;
   logic                                gt_ff, gt_in;
   logic                                ge_ff, ge_in;
   logic [kpt_pkg::DIGIT_CNT_BITS-1:0]  cnt_ff, cnt_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [kpt_pkg::RSP_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   // divider hookup
   logic                                div_start;
   logic                                div_done;
   logic [kpt_pkg::FRACTION_BITS-1:0]   div_quot;

   // per-digit logic
   logic [D-1:0]                        a_dig, b_dig, c_dig, dif_dig;
   logic [D:0]                          sub_w, add_w;
   logic                                gt_nx, ge_nx, last_dig;
   kpt_pkg::pos_type                    pos_full, pos_div;

   logic                                req_fire;
   logic                                req_dir;
   kpt_pkg::time_type                   req_now;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_dir    = req_tdata[0];
   assign req_now    = req_tdata[T:1];

   // digit lane, LSB first; pass 1 subtracts opnd, pass 2 subtracts the limit itself
   assign a_dig   = elap_ff[D-1:0];
   assign c_dig   = cmp_ff[D-1:0];
   assign b_dig   = (state_ff == S_PASS1) ? opnd_ff[D-1:0] : c_dig;
   assign sub_w   = {1'b0, a_dig} - {1'b0, b_dig} - {{D{1'b0}}, borrow_ff};
   assign dif_dig = sub_w[D-1:0];
   assign add_w   = {1'b0, tstart_ff[D-1:0]} + {1'b0, c_dig} + {{D{1'b0}}, carry_ff};
   // LSB-first magnitude compare: a higher digit decides, equal digits keep the verdict
   assign gt_nx   = (dif_dig > c_dig) || ((dif_dig == c_dig) && gt_ff);
   assign ge_nx   = (dif_dig > c_dig) || ((dif_dig == c_dig) && ge_ff);
   assign last_dig = (cnt_ff == kpt_pkg::DIGIT_CNT_BITS'(kpt_pkg::DIGITS - 1));

   // saturated position, 1.0 or 0 in reverse
   assign pos_full = reverse_ff ? '0 : kpt_pkg::FIX_ONE;
   assign pos_div  = reverse_ff ? (kpt_pkg::FIX_ONE - {1'b0, div_quot}) : {1'b0, div_quot};

   assign div_start = (state_ff == S_DIVGO);

   kpt_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (elap_ff),
      .den   (duration_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      reverse_in     = reverse_ff;
      delay_start_in = delay_start_ff;
      tstart_in      = tstart_ff;
      position_in    = position_ff;
      event_in       = event_ff;
      now_in         = now_ff;
      elap_in        = elap_ff;
      opnd_in        = opnd_ff;
      cmp_in         = cmp_ff;
      borrow_in      = borrow_ff;
      carry_in       = carry_ff;
      gt_in          = gt_ff;
      ge_in          = ge_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in   = req_now;
               event_in = 1'b0;
               state_in = S_DONE;
               if (req_tuser == kpt_pkg::OP_PLAY) begin
                  if ((phase_ff == kpt_pkg::PH_IDLE) && !req_dir) begin
                     position_in = '0;
                  end
                  reverse_in     = req_dir;
                  phase_in       = kpt_pkg::PH_DELAY;
                  delay_start_in = req_now;
               end else if (phase_ff == kpt_pkg::PH_DELAY ||
                            phase_ff == kpt_pkg::PH_TRANS) begin
                  elap_in   = req_now;
                  opnd_in   = (phase_ff == kpt_pkg::PH_DELAY) ? delay_start_ff : tstart_ff;
                  cmp_in    = (phase_ff == kpt_pkg::PH_DELAY) ? delay_ff : duration_ff;
                  borrow_in = 1'b0;
                  gt_in     = 1'b0;
                  ge_in     = 1'b1;
                  cnt_in    = '0;
                  state_in  = S_PASS1;
               end
            end
         end

         S_PASS1: begin
            elap_in   = {dif_dig, elap_ff[T-1:D]};
            opnd_in   = {{D{1'b0}}, opnd_ff[T-1:D]};
            cmp_in    = {c_dig, cmp_ff[T-1:D]};
            borrow_in = sub_w[D];
            gt_in     = gt_nx;
            ge_in     = ge_nx;
            cnt_in    = cnt_ff + 1'b1;
            if (last_dig) begin
               if (phase_ff == kpt_pkg::PH_DELAY) begin
                  if (ge_nx) begin
                     phase_in  = kpt_pkg::PH_TRANS;
                     tstart_in = now_ff;
                  end
                  state_in = S_DONE;
               end else begin
                  event_in = 1'b1;
                  if (gt_nx && looping_ff) begin
                     borrow_in = 1'b0;
                     carry_in  = 1'b0;
                     gt_in     = 1'b0;
                     ge_in     = 1'b1;
                     cnt_in    = '0;
                     state_in  = S_PASS2;
                  end else if (gt_nx) begin
                     // overrun, no loop: clamp to the end and stop
                     phase_in    = kpt_pkg::PH_IDLE;
                     position_in = pos_full;
                     state_in    = S_DONE;
                  end else if (ge_nx) begin
                     // exactly at the end, or zero duration
                     position_in = pos_full;
                     state_in    = S_DONE;
                  end else begin
                     state_in = S_DIVGO;
                  end
               end
            end
         end

         S_PASS2: begin
            elap_in   = {dif_dig, elap_ff[T-1:D]};
            cmp_in    = {c_dig, cmp_ff[T-1:D]};
            tstart_in = {add_w[D-1:0], tstart_ff[T-1:D]};
            borrow_in = sub_w[D];
            carry_in  = add_w[D];
            gt_in     = gt_nx;
            ge_in     = ge_nx;
            cnt_in    = cnt_ff + 1'b1;
            if (last_dig) begin
               if (ge_nx) begin
                  position_in = pos_full;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_DIVGO;
               end
            end
         end

         S_DIVGO: begin
            state_in = S_DIV;
         end

         S_DIV: begin
            if (div_done) begin
               position_in = pos_div;
               state_in    = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(kpt_pkg::RSP_DATA_BITS - kpt_pkg::RSP_FIELD_BITS){1'b0}},
                               event_ff, phase_ff, position_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         duration_ff    <= '0;
         delay_ff       <= '0;
         looping_ff     <= 1'b0;
         phase_ff       <= kpt_pkg::PH_IDLE;
         reverse_ff     <= 1'b0;
         delay_start_ff <= '0;
         tstart_ff      <= '0;
         position_ff    <= '0;
         event_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         reverse_ff     <= reverse_in;
         delay_start_ff <= delay_start_in;
         tstart_ff      <= tstart_in;
         position_ff    <= position_in;
         event_ff       <= event_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               kpt_pkg::CSR_DURATION: duration_ff <= csr_wdata[T-1:0];
               kpt_pkg::CSR_DELAY:    delay_ff    <= csr_wdata[T-1:0];
               kpt_pkg::CSR_LOOPING:  looping_ff  <= csr_wdata[0];
               default: ;  // unknown index: write dropped
            endcase
         end
      end
      now_ff      <= now_in;
      elap_ff     <= elap_in;
      opnd_ff     <= opnd_in;
      cmp_ff      <= cmp_in;
      borrow_ff   <= borrow_in;
      carry_ff    <= carry_in;
      gt_ff       <= gt_in;
      ge_ff       <= ge_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/kpt_checker.sv]
// Port-level checks for the keyframe progress timer, bound to the top level.
module kpt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [kpt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic [kpt_pkg::POS_BITS-1:0]   pos;
   logic [kpt_pkg::PHASE_BITS-1:0] phase;
   logic                           evt;

   assign pos   = rsp_tdata[kpt_pkg::POS_BITS-1:0];
   assign phase = rsp_tdata[kpt_pkg::RSP_PHASE_LSB +: kpt_pkg::PHASE_BITS];
   assign evt   = rsp_tdata[kpt_pkg::RSP_EVENT_BIT];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item at a time: no accept right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted while busy");

   // position never beyond 1.0
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos <= kpt_pkg::FIX_ONE))
      else $error("position above 1.0");

   // a progress update never leaves the block waiting in the delay phase
   a_evt_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && evt |-> (phase == kpt_pkg::PH_TRANS || phase == kpt_pkg::PH_IDLE))
      else $error("progress update in delay phase");

   // an update that ends in idle stops at an end point
   a_stop_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && evt && (phase == kpt_pkg::PH_IDLE) |->
         (pos == kpt_pkg::FIX_ONE || pos == '0))
      else $error("stop not at an end point");

endmodule

bind keyframe_progress_timer kpt_checker u_kpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
